### hw/rtl/pcs_pkg.sv
// ---------------------------------------------------------------------------
// pcs_pkg
// Register map, register field width and knee reset levels of the
// piecewise contrast stretch block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcs_pkg;

  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 8;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_KNEE1_IN  = 2'd0,
    REG_KNEE1_OUT = 2'd1,
    REG_KNEE2_IN  = 2'd2,
    REG_KNEE2_OUT = 2'd3
  } pcs_reg_t;

  localparam logic [CFG_DATA_BITS-1:0] KNEE1_IN_RST  = 8'd64;
  localparam logic [CFG_DATA_BITS-1:0] KNEE1_OUT_RST = 8'd64;
  localparam logic [CFG_DATA_BITS-1:0] KNEE2_IN_RST  = 8'd192;
  localparam logic [CFG_DATA_BITS-1:0] KNEE2_OUT_RST = 8'd192;

endpackage

### hw/rtl/piecewise_contrast_stretch.sv
// ---------------------------------------------------------------------------
// piecewise_contrast_stretch
// Throughput: one pixel per clock, set by the restoring divider that resolves
// one quotient bit in each pipeline stage.
// Reset: rst_n (synchronous) clears all valid bits and loads the default knees
// (64,64) and (192,192); busy and not cfg_ready during reset only.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_contrast_stretch #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [PIXEL_BITS-1:0]               in_pixel_in,
  output logic                                out_valid,
  output logic [PIXEL_BITS-1:0]               out_pixel_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcs_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [pcs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int W   = PIXEL_BITS;
  localparam int KB  = (PIXEL_BITS < pcs_pkg::CFG_DATA_BITS) ? PIXEL_BITS
                                                              : pcs_pkg::CFG_DATA_BITS;
  localparam int LAT = PIXEL_BITS + 3;
  localparam logic [W-1:0] MAXV     = {W{1'b1}};
  localparam logic [W-1:0] OUT_MASK = W'((64'd1 << KB) - 64'd1);

  typedef struct packed {
    logic         neg;
    logic [W-1:0] base;
    logic [W-1:0] den;
  } side_t;

  // knee registers
  logic [W-1:0] knee1_in_r, knee1_out_r, knee2_in_r, knee2_out_r;
  logic [W-1:0] cfg_level;
  logic         accept;

  assign busy      = !rst_n;
  assign cfg_ready = rst_n;
  assign accept    = start && !busy;
  assign cfg_level = W'(cfg_data[KB-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knee1_in_r  <= W'(pcs_pkg::KNEE1_IN_RST[KB-1:0]);
      knee1_out_r <= W'(pcs_pkg::KNEE1_OUT_RST[KB-1:0]);
      knee2_in_r  <= W'(pcs_pkg::KNEE2_IN_RST[KB-1:0]);
      knee2_out_r <= W'(pcs_pkg::KNEE2_OUT_RST[KB-1:0]);
    end else if (cfg_valid && cfg_ready) begin
      case (pcs_pkg::pcs_reg_t'(cfg_addr))
        pcs_pkg::REG_KNEE1_IN:  knee1_in_r  <= cfg_level;
        pcs_pkg::REG_KNEE1_OUT: knee1_out_r <= cfg_level;
        pcs_pkg::REG_KNEE2_IN:  knee2_in_r  <= cfg_level;
        pcs_pkg::REG_KNEE2_OUT: knee2_out_r <= cfg_level;
        default: ;
      endcase
    end
  end

  // stage 1: segment select and operands
  logic [W-1:0] op_a_nxt, op_b_nxt;
  side_t        s1_side_nxt;
  logic [W-1:0] op_a_r, op_b_r;
  side_t        s1_side_r;
  logic         s1_vld_r;

  always_comb begin
    op_a_nxt    = '0;
    op_b_nxt    = '0;
    s1_side_nxt = '0;
    if (in_pixel_in <= knee1_in_r) begin
      if (knee1_in_r == '0) begin
        s1_side_nxt.base = knee1_out_r;
        s1_side_nxt.den  = W'(1);
      end else begin
        op_a_nxt         = knee1_out_r;
        op_b_nxt         = in_pixel_in;
        s1_side_nxt.den  = knee1_in_r;
      end
    end else if (in_pixel_in <= knee2_in_r) begin
      s1_side_nxt.base = knee1_out_r;
      s1_side_nxt.neg  = knee2_out_r < knee1_out_r;
      op_a_nxt         = s1_side_nxt.neg ? knee1_out_r - knee2_out_r
                                         : knee2_out_r - knee1_out_r;
      op_b_nxt         = in_pixel_in - knee1_in_r;
      s1_side_nxt.den  = knee2_in_r - knee1_in_r;
    end else begin
      s1_side_nxt.base = knee2_out_r;
      op_a_nxt         = MAXV - knee2_out_r;
      op_b_nxt         = in_pixel_in - knee2_in_r;
      s1_side_nxt.den  = MAXV - knee2_in_r;
    end
  end

  always_ff @(posedge clk) begin
    op_a_r    <= op_a_nxt;
    op_b_r    <= op_b_nxt;
    s1_side_r <= s1_side_nxt;
  end

  // stage 2 (index 0) holds the product, indices 1..W resolve one quotient bit each
  logic [2*W-1:0] prod;
  logic [W-1:0]   rem_r  [0:W];
  logic [W-1:0]   lq_r   [0:W];
  side_t          side_r [0:W];
  logic [W:0]     dv_vld_r;
  logic [W-1:0]   rem_nxt [0:W-1];
  logic [W-1:0]   lq_nxt  [0:W-1];
  logic [W:0]     trial   [0:W-1];
  logic [W:0]     diff    [0:W-1];

  assign prod = (2*W)'(op_a_r) * (2*W)'(op_b_r);

  always_comb begin
    for (int i = 0; i < W; i++) begin
      trial[i]   = {rem_r[i], lq_r[i][W-1]};
      diff[i]    = trial[i] - {1'b0, side_r[i].den};
      if (trial[i] >= {1'b0, side_r[i].den}) begin
        rem_nxt[i] = diff[i][W-1:0];
        lq_nxt[i]  = {lq_r[i][W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[i][W-1:0];
        lq_nxt[i]  = {lq_r[i][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= prod[2*W-1:W];
    lq_r[0]   <= prod[W-1:0];
    side_r[0] <= s1_side_r;
    for (int i = 0; i < W; i++) begin
      rem_r[i+1]  <= rem_nxt[i];
      lq_r[i+1]   <= lq_nxt[i];
      side_r[i+1] <= side_r[i];
    end
  end

  // output stage
  logic [W-1:0] res_nxt;
  logic [W-1:0] out_pixel_r;
  logic         out_valid_r;

  always_comb begin
    if (side_r[W].neg) begin
      res_nxt = side_r[W].base - lq_r[W];
    end else begin
      res_nxt = side_r[W].base + lq_r[W];
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= res_nxt & OUT_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      dv_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= accept;
      dv_vld_r    <= {dv_vld_r[W-1:0], s1_vld_r};
      out_valid_r <= dv_vld_r[W];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

  // checks
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted pixel did not produce a result on time");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching start transfer");

  a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[W] |-> (rem_r[W] < side_r[W].den))
    else $error("divider remainder not below divisor");

endmodule
